/* rtl/core/min_cost_jump_path_top_assert.svh */
// Assertion macros for the minimum-cost jump path block.
`ifndef MIN_COST_JUMP_PATH_TOP_ASSERT_SVH
`define MIN_COST_JUMP_PATH_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, sampled on clk, off while rst_n is low
`define MCJP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mcjp assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low
`define MCJP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mcjp assertion failed");

`else

`define MCJP_ASSERT_NOW(lbl, ante, cons)
`define MCJP_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

/* rtl/core/mcjp_pkg.sv */
// Package for the minimum-cost jump path block: widths, defaults, codes, types.
package mcjp_pkg;

  localparam int NUM_JUMPS_DEF    = 4;
  localparam int MAX_POSITION_DEF = 63;

  localparam int POS_W      = 6;
  localparam int COST_W     = 8;
  localparam int TOTAL_W    = 14;
  localparam int CHOICE_W   = 2;
  localparam int NUM_SLOTS  = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  localparam logic [POS_W-1:0]  RESET_SIZE [NUM_SLOTS] = '{6'd2, 6'd5, 6'd3, 6'd7};
  localparam logic [COST_W-1:0] RESET_COST [NUM_SLOTS] = '{8'd1, 8'd1, 8'd4, 8'd1};

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_JUMP_SIZE_0,
    REG_JUMP_SIZE_1,
    REG_JUMP_SIZE_2,
    REG_JUMP_SIZE_3,
    REG_JUMP_COST_0,
    REG_JUMP_COST_1,
    REG_JUMP_COST_2,
    REG_JUMP_COST_3
  } reg_idx_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_FILL,
    ST_BT_RD,
    ST_BT_EMIT,
    ST_SINGLE
  } state_t;

  // One cost table entry
  typedef struct packed {
    logic                reached;
    logic [CHOICE_W-1:0] choice;
    logic [TOTAL_W-1:0]  cost;
  } entry_t;

endpackage

/* rtl/core/min_cost_jump_path_top.sv */
// Minimum-cost jump path: table fill with one shared adder/comparator, then backtrack.
// For target T in 1..MAX_POSITION the table is filled up to T, then the path is walked back
// with one result per cycle while the output side takes them.
// Target 0 or above MAX_POSITION: one result, with no table fill.
// One request at a time; the fill loop over positions and jumps sets the rate.
// Sync active-low reset: config to defaults, sequencer idle; cost table is not cleared.
`include "min_cost_jump_path_top_assert.svh"

module min_cost_jump_path_top
  import mcjp_pkg::*;
#(
  parameter int NUM_JUMPS    = NUM_JUMPS_DEF,
  parameter int MAX_POSITION = MAX_POSITION_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // request channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [POS_W-1:0]      in_target_position,
  // result channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_reachable,
  output logic [POS_W-1:0]      out_jump_size,
  output logic [CHOICE_W-1:0]   out_jump_choice,
  output logic [TOTAL_W-1:0]    out_total_cost,
  output logic                  out_last
);

  localparam int DEPTH = MAX_POSITION + 1;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int JCW   = $clog2(NUM_JUMPS + 1);
  localparam logic [JCW-1:0] J_LAST = JCW'(NUM_JUMPS);

  // configuration registers
  logic [POS_W-1:0]  jump_size_r [NUM_SLOTS];
  logic [COST_W-1:0] jump_cost_r [NUM_SLOTS];

  // sequencer and datapath registers
  state_t              state_r, state_nxt;
  logic [AW-1:0]       p_r, p_nxt;
  logic [AW-1:0]       target_r, target_nxt;
  logic [JCW-1:0]      j_r, j_nxt;
  logic                cand_v_r, cand_v_nxt;
  logic [CHOICE_W-1:0] cand_j_r, cand_j_nxt;
  logic                found_r, found_nxt;
  logic [TOTAL_W-1:0]  best_r, best_nxt;
  logic [CHOICE_W-1:0] pick_r, pick_nxt;
  logic [TOTAL_W-1:0]  total_r, total_nxt;
  logic                single_reach_r, single_reach_nxt;

  // output register
  logic                out_valid_r;
  logic                out_reach_r, out_reach_nxt;
  logic [POS_W-1:0]    out_size_r, out_size_nxt;
  logic [CHOICE_W-1:0] out_choice_r, out_choice_nxt;
  logic [TOTAL_W-1:0]  out_total_r, out_total_nxt;
  logic                out_last_r, out_last_nxt;
  logic                out_load;
  logic                out_free;

  // cost table
  entry_t              mem [DEPTH];
  entry_t              rd_q;
  logic [AW-1:0]       rd_addr;
  logic                mem_we;
  logic [AW-1:0]       wr_addr;
  entry_t              wr_data;

  // shared compare unit signals
  logic [TOTAL_W:0]    cand_c;
  logic                cand_better;
  logic                found_n;
  logic [TOTAL_W-1:0]  best_n;
  logic [CHOICE_W-1:0] pick_n;
  logic [POS_W-1:0]    p_ext;
  logic [POS_W-1:0]    js;
  logic                js_ok;
  logic [POS_W-1:0]    bt_size;
  logic [POS_W-1:0]    bt_p_next;
  logic                accept;
  logic                single_req;

  assign accept     = in_valid && in_ready;
  assign single_req = (in_target_position == '0) ||
                      (in_target_position > POS_W'(MAX_POSITION));
  assign out_free   = !out_valid_r || out_ready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_SLOTS; k++) begin
        jump_size_r[k] <= RESET_SIZE[k];
        jump_cost_r[k] <= RESET_COST[k];
      end
    end else if (cfg_we) begin
      unique case (cfg_index) inside
        REG_JUMP_SIZE_0, REG_JUMP_SIZE_1, REG_JUMP_SIZE_2, REG_JUMP_SIZE_3: begin
          jump_size_r[cfg_index[1:0]] <= cfg_data[POS_W-1:0];
        end
        REG_JUMP_COST_0, REG_JUMP_COST_1, REG_JUMP_COST_2, REG_JUMP_COST_3: begin
          jump_cost_r[cfg_index[1:0]] <= cfg_data[COST_W-1:0];
        end
      endcase
    end
  end

  // cost table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  // shared add and compare: candidate read last cycle against running best
  assign cand_c      = {1'b0, rd_q.cost} + (TOTAL_W+1)'(jump_cost_r[cand_j_r]);
  assign cand_better = cand_v_r && rd_q.reached &&
                       (!found_r || (cand_c < {1'b0, best_r}));
  assign found_n     = found_r || cand_better;
  assign best_n      = cand_better ? cand_c[TOTAL_W-1:0] : best_r;
  assign pick_n      = cand_better ? cand_j_r : pick_r;

  // candidate address for the jump being issued
  assign p_ext = POS_W'(p_r);
  assign js    = jump_size_r[CHOICE_W'(j_r)];
  assign js_ok = (js != '0) && (js <= p_ext);

  // backtrack step from the entry just read
  assign bt_size   = jump_size_r[rd_q.choice];
  assign bt_p_next = p_ext - bt_size;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = single_req ? ST_SINGLE : ST_START;
        end
      end
      ST_START: begin
        state_nxt = ST_FILL;
      end
      ST_FILL: begin
        if (j_r == J_LAST && p_r == target_r) begin
          state_nxt = ST_BT_RD;
        end
      end
      ST_BT_RD: begin
        state_nxt = ST_BT_EMIT;
      end
      ST_BT_EMIT: begin
        if (out_free && (!rd_q.reached || bt_p_next == '0)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SINGLE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
    endcase
  end

  // datapath and outputs per state
  always_comb begin
    p_nxt            = p_r;
    target_nxt       = target_r;
    j_nxt            = j_r;
    cand_v_nxt       = 1'b0;
    cand_j_nxt       = cand_j_r;
    found_nxt        = found_r;
    best_nxt         = best_r;
    pick_nxt         = pick_r;
    total_nxt        = total_r;
    single_reach_nxt = single_reach_r;
    rd_addr          = p_r;
    mem_we           = 1'b0;
    wr_addr          = p_r;
    wr_data          = '0;
    out_load         = 1'b0;
    out_reach_nxt    = 1'b0;
    out_size_nxt     = '0;
    out_choice_nxt   = '0;
    out_total_nxt    = '0;
    out_last_nxt     = 1'b1;
    in_ready         = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready         = 1'b1;
        target_nxt       = AW'(in_target_position);
        single_reach_nxt = (in_target_position == '0);
        p_nxt            = AW'(1);
      end
      ST_START: begin
        // position 0 is the start and costs nothing
        mem_we    = 1'b1;
        wr_addr   = '0;
        wr_data   = '{reached: 1'b1, choice: '0, cost: '0};
        j_nxt     = '0;
        found_nxt = 1'b0;
        best_nxt  = '0;
        pick_nxt  = '0;
      end
      ST_FILL: begin
        found_nxt = found_n;
        best_nxt  = best_n;
        pick_nxt  = pick_n;
        if (j_r == J_LAST) begin
          // last compare folds into the table write
          mem_we    = 1'b1;
          wr_addr   = p_r;
          wr_data   = '{reached: found_n, choice: pick_n,
                        cost: found_n ? best_n : '0};
          total_nxt = best_n;
          found_nxt = 1'b0;
          best_nxt  = '0;
          pick_nxt  = '0;
          j_nxt     = '0;
          if (p_r != target_r) begin
            p_nxt = p_r + AW'(1);
          end
        end else begin
          rd_addr    = AW'(p_ext - js);
          cand_v_nxt = js_ok;
          cand_j_nxt = CHOICE_W'(j_r);
          j_nxt      = j_r + JCW'(1);
        end
      end
      ST_BT_RD: begin
        rd_addr = p_r;
      end
      ST_BT_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          if (rd_q.reached) begin
            out_reach_nxt  = 1'b1;
            out_size_nxt   = bt_size;
            out_choice_nxt = rd_q.choice;
            out_total_nxt  = total_r;
            out_last_nxt   = (bt_p_next == '0);
            p_nxt          = AW'(bt_p_next);
            rd_addr        = AW'(bt_p_next);
          end
        end
      end
      ST_SINGLE: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_reach_nxt = single_reach_r;
        end
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cand_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cand_v_r <= cand_v_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    p_r            <= p_nxt;
    target_r       <= target_nxt;
    j_r            <= j_nxt;
    cand_j_r       <= cand_j_nxt;
    found_r        <= found_nxt;
    best_r         <= best_nxt;
    pick_r         <= pick_nxt;
    total_r        <= total_nxt;
    single_reach_r <= single_reach_nxt;
    if (out_load) begin
      out_reach_r  <= out_reach_nxt;
      out_size_r   <= out_size_nxt;
      out_choice_r <= out_choice_nxt;
      out_total_r  <= out_total_nxt;
      out_last_r   <= out_last_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_reachable   = out_reach_r;
  assign out_jump_size   = out_size_r;
  assign out_jump_choice = out_choice_r;
  assign out_total_cost  = out_total_r;
  assign out_last        = out_last_r;

  // checks
  `MCJP_ASSERT_NEXT(a_busy_after_req, accept, !in_ready)
  `MCJP_ASSERT_NOW(a_cand_in_range, cand_v_r, JCW'(cand_j_r) < J_LAST)
  `MCJP_ASSERT_NOW(a_zero_jump_final, out_valid && out_reachable && out_jump_size == '0,
                   out_last && out_total_cost == '0)
  `MCJP_ASSERT_NOW(a_write_in_fill, mem_we, state_r == ST_START || state_r == ST_FILL)

endmodule

/* sim/min_cost_jump_path_top_test.sv */
// Testbench for min_cost_jump_path_top: randomized requests checked against a local path predictor.
`timescale 1ns / 100ps

module min_cost_jump_path_top_test;
  import mcjp_pkg::*;

  localparam int CYCLE_LIMIT  = 1_500_000;
  localparam int SETTLE_TICKS = 8;
  localparam int IDLE_PCT     = 27;

  // One expected hop of a path, as the block reports it
  typedef struct {
    logic                reachable;
    logic [POS_W-1:0]    jump_size;
    logic [CHOICE_W-1:0] jump_choice;
    logic [TOTAL_W-1:0]  total_cost;
    logic                last;
  } hop_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_JUMP_SIZE_0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [POS_W-1:0]      in_target_position = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  out_reachable;
  logic [POS_W-1:0]      out_jump_size;
  logic [CHOICE_W-1:0]   out_jump_choice;
  logic [TOTAL_W-1:0]    out_total_cost;
  logic                  out_last;

  // Predictor copy of the jump configuration
  logic [POS_W-1:0]  jump_len [NUM_SLOTS];
  logic [COST_W-1:0] jump_fee [NUM_SLOTS];

  logic [POS_W-1:0] target_backlog [$];
  hop_t             hop_expect [$];
  int               mismatch_count = 0;
  int               cycle_count = 0;
  bit               quiet = 1'b0;

  min_cost_jump_path_top dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_target_position (in_target_position),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_reachable      (out_reachable),
    .out_jump_size      (out_jump_size),
    .out_jump_choice    (out_jump_choice),
    .out_total_cost     (out_total_cost),
    .out_last           (out_last)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Append helpers for the two pending queues
  function automatic void add_target(input logic [POS_W-1:0] t);
    target_backlog.insert(target_backlog.size(), t);
  endfunction

  function automatic void add_hop(input hop_t h);
    hop_expect.insert(hop_expect.size(), h);
  endfunction

  // Fill the cost table up to the target, then walk back and queue the hops
  task automatic predict_path(input logic [POS_W-1:0] target);
    int unsigned         cost_tab [64];
    bit                  reach_tab [64];
    logic [CHOICE_W-1:0] pick_tab [64];
    int unsigned         best;
    int unsigned         c;
    bit                  found;
    logic [CHOICE_W-1:0] pick;
    int                  p;
    int                  s;
    logic [CHOICE_W-1:0] ch;
    hop_t                h;
    if (target == 0) begin
      h = '{1'b1, '0, '0, '0, 1'b1};
      add_hop(h);
      return;
    end
    cost_tab[0] = 0;
    reach_tab[0] = 1'b1;
    pick_tab[0] = '0;
    for (p = 1; p <= target; p++) begin
      found = 1'b0;
      best = 0;
      pick = '0;
      for (int j = 0; j < NUM_JUMPS_DEF; j++) begin
        s = jump_len[j];
        // a zero-length jump points at itself and never counts
        if (s == 0 || s > p) continue;
        if (!reach_tab[p - s]) continue;
        c = cost_tab[p - s] + jump_fee[j];
        // strict compare keeps the lowest index on a tie
        if (!found || c < best) begin
          found = 1'b1;
          best = c;
          pick = j[CHOICE_W-1:0];
        end
      end
      reach_tab[p] = found;
      cost_tab[p] = found ? (best & 32'h7FFF) : 0;
      pick_tab[p] = pick;
    end
    if (!reach_tab[target]) begin
      h = '{1'b0, '0, '0, '0, 1'b1};
      add_hop(h);
      return;
    end
    p = target;
    while (p > 0) begin
      ch = pick_tab[p];
      s = jump_len[ch];
      p = p - s;
      h.reachable = 1'b1;
      h.jump_size = s[POS_W-1:0];
      h.jump_choice = ch;
      h.total_cost = cost_tab[target][TOTAL_W-1:0];
      h.last = (p == 0);
      add_hop(h);
    end
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Request driver: predicts on acceptance, then offers the next target
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) predict_path(in_target_position);
      if (!in_valid || in_ready) begin
        if (target_backlog.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
          in_valid <= 1'b1;
          in_target_position <= target_backlog.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random back-pressure
  always @(posedge clk) begin : watch_hops
    hop_t h;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (hop_expect.size() == 0) begin
          $display("%0t: result with none pending, got reach %0d size %0d choice %0d cost %0d last %0d",
                   $time, out_reachable, out_jump_size, out_jump_choice, out_total_cost,
                   out_last);
          mismatch_count++;
        end else begin
          h = hop_expect.pop_front();
          check_field("reachable", h.reachable, out_reachable);
          check_field("jump_size", h.jump_size, out_jump_size);
          check_field("jump_choice", h.jump_choice, out_jump_choice);
          check_field("total_cost", h.total_cost, out_total_cost);
          check_field("last", h.last, out_last);
        end
      end
      out_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      REG_JUMP_SIZE_0: jump_len[0] = data[POS_W-1:0];
      REG_JUMP_SIZE_1: jump_len[1] = data[POS_W-1:0];
      REG_JUMP_SIZE_2: jump_len[2] = data[POS_W-1:0];
      REG_JUMP_SIZE_3: jump_len[3] = data[POS_W-1:0];
      REG_JUMP_COST_0: jump_fee[0] = data;
      REG_JUMP_COST_1: jump_fee[1] = data;
      REG_JUMP_COST_2: jump_fee[2] = data;
      REG_JUMP_COST_3: jump_fee[3] = data;
      default: ;
    endcase
  endtask

  task automatic load_jumps(input logic [7:0] s0, s1, s2, s3, c0, c1, c2, c3);
    write_reg(REG_JUMP_SIZE_0, s0);
    write_reg(REG_JUMP_SIZE_1, s1);
    write_reg(REG_JUMP_SIZE_2, s2);
    write_reg(REG_JUMP_SIZE_3, s3);
    write_reg(REG_JUMP_COST_0, c0);
    write_reg(REG_JUMP_COST_1, c1);
    write_reg(REG_JUMP_COST_2, c2);
    write_reg(REG_JUMP_COST_3, c3);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Mostly short jumps so paths get long; stray upper data bits on size writes
  function automatic logic [7:0] rand_size();
    logic [5:0] s;
    s = ($urandom_range(9) < 6) ? 6'($urandom_range(1, 8)) : 6'($urandom_range(1, 63));
    return {$urandom_range(3) == 0 ? 2'($urandom_range(3)) : 2'b00, s};
  endfunction

  // Either the full range or a narrow one that makes ties likely
  function automatic logic [7:0] rand_cost(input bit narrow);
    return narrow ? 8'($urandom_range(0, 2)) : 8'($urandom_range(0, 255));
  endfunction

  task automatic random_jumps();
    bit narrow;
    narrow = $urandom_range(1);
    load_jumps(rand_size(), rand_size(), rand_size(), rand_size(),
               rand_cost(narrow), rand_cost(narrow), rand_cost(narrow), rand_cost(narrow));
  endtask

  task automatic queue_random(input int n);
    repeat (n) add_target(POS_W'($urandom_range(0, 63)));
  endtask

  // Wait until every request is in and every hop is out, then let the block go idle
  task automatic settle();
    @(negedge clk);
    while (target_backlog.size() != 0 || in_valid || hop_expect.size() != 0)
      @(negedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  initial begin : sequence_run
    logic [POS_W-1:0] directed [15] = '{0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 13, 21, 42, 62, 63};
    for (int k = 0; k < NUM_SLOTS; k++) begin
      jump_len[k] = RESET_SIZE[k];
      jump_fee[k] = RESET_COST[k];
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset configuration: small targets, unreachable one, the bit patterns, the largest
    foreach (directed[i]) add_target(directed[i]);
    queue_random(50);
    settle();

    // Unit jumps at the top cost: longest path and largest total
    load_jumps(8'd1, 8'd1, 8'd1, 8'd1, 8'd255, 8'd255, 8'd255, 8'd255);
    add_target(6'd63);
    add_target(6'd62);
    add_target(6'd1);
    add_target(6'd0);
    queue_random(12);
    settle();

    // Longest jumps at zero cost: only 0 and 63 reachable
    load_jumps(8'd63, 8'd63, 8'd63, 8'd63, 8'd0, 8'd0, 8'd0, 8'd0);
    add_target(6'd63);
    add_target(6'd62);
    add_target(6'd0);
    queue_random(12);
    settle();

    // Zero-length jump, written with stray upper bits, must never be taken
    load_jumps(8'hC0, 8'd1, 8'd2, 8'd3, 8'd0, 8'd5, 8'd3, 8'd1);
    add_target(6'd1);
    add_target(6'd63);
    add_target(6'd0);
    queue_random(20);
    settle();

    // Random configurations; one runs with both sides never idling
    for (int ph = 0; ph < 6; ph++) begin
      random_jumps();
      quiet = (ph == 2);
      queue_random(27);
      settle();
    end
    quiet = 1'b0;

    repeat (SETTLE_TICKS) @(posedge clk);
    if (mismatch_count == 0 && hop_expect.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
